FILE: src/svna_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svna_pkg
// Shared types, widths and opcodes of the smoothed vertex normal accumulator.
// ----------------------------------------------------------------------------
package svna_pkg;

  localparam int INDEX_W  = 10;
  localparam int PORT_CW  = 24;
  localparam int SUM_W    = 24;
  localparam int NRM_W    = 16;
  localparam int MAG_W    = 63;
  localparam int FR_W     = 30;
  localparam int LEN2_W   = 62;
  localparam int LEN_W    = 31;
  localparam int DIV_BITS = 16;

  typedef logic [1:0]                opcode_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic signed [PORT_CW-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [NRM_W-1:0]   nrm_t;

  localparam opcode_t OP_LOAD  = 2'd0;
  localparam opcode_t OP_FACE  = 2'd1;
  localparam opcode_t OP_READ  = 2'd2;
  localparam opcode_t OP_CLEAR = 2'd3;

  localparam sum_t SUM_MAX = 24'sh7FFFFF;
  localparam sum_t SUM_MIN = 24'sh800000;
  localparam nrm_t NRM_MAX = 16'sh7FFF;
  localparam nrm_t NRM_MIN = 16'sh8000;

endpackage
`default_nettype wire

FILE: src/smooth_vertex_normal_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smooth_vertex_normal_accumulator
// Per-vertex smoothed normals: loads positions, adds unit face normals to the
// three corners, and returns the normalized sum of a vertex on read.
//
// Command channel: an item is taken on a clock edge with start high and busy
// low; busy then stays high until its result is out. Every item gives one
// result, shown for one cycle with done high; the receiver cannot stall it.
// Non-read items return present 0 and zero normals.
// A face item with an index out of range changes nothing; a clear item
// zeroes the sum memory one entry per cycle. A read of an untouched vertex
// returns present 0; a touched vertex with a zero sum returns zero normals.
// Face and read items share one 32x32 multiplier (cross product and
// squares) and use a normalizing shift of 1 to 10 steps, a bit-pair square
// root of 32 steps and a restoring divider of 16 steps per component; a
// face item ends with a read-modify-write of each of its three corners.
// Reset starts a clearing pass over the sum memory, with busy high; the
// block takes no item before it ends.
// ----------------------------------------------------------------------------
module smooth_vertex_normal_accumulator #(
  parameter int VERTEX_COUNT = 1024,
  parameter int COORD_WIDTH  = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  svna_pkg::opcode_t opcode,
  input  svna_pkg::index_t index_a,
  input  svna_pkg::index_t index_b,
  input  svna_pkg::index_t index_c,
  input  svna_pkg::coord_t coord_x,
  input  svna_pkg::coord_t coord_y,
  input  svna_pkg::coord_t coord_z,
  output logic             done,
  output logic             present,
  output svna_pkg::nrm_t   normal_x,
  output svna_pkg::nrm_t   normal_y,
  output svna_pkg::nrm_t   normal_z
);
  import svna_pkg::*;

  localparam int ADDR_W   = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int CW       = COORD_WIDTH;
  localparam int DIFF_SHR = (CW > 30) ? CW - 30 : 0;
  localparam int POS_W    = 3 * CW;
  localparam int SMEM_W   = 3 * SUM_W + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VERTEX_COUNT - 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_LOAD  = 5'd2;
  localparam logic [4:0] S_DONE  = 5'd3;
  localparam logic [4:0] S_FRD   = 5'd4;
  localparam logic [4:0] S_FDIFF = 5'd5;
  localparam logic [4:0] S_FMUL  = 5'd6;
  localparam logic [4:0] S_RRD   = 5'd7;
  localparam logic [4:0] S_RCHK  = 5'd8;
  localparam logic [4:0] S_NMAG  = 5'd9;
  localparam logic [4:0] S_NSH   = 5'd10;
  localparam logic [4:0] S_NAPP  = 5'd11;
  localparam logic [4:0] S_NSQ   = 5'd12;
  localparam logic [4:0] S_NSQRT = 5'd13;
  localparam logic [4:0] S_NDSET = 5'd14;
  localparam logic [4:0] S_NDIV  = 5'd15;
  localparam logic [4:0] S_NEND  = 5'd16;
  localparam logic [4:0] S_FACC  = 5'd17;

  logic [4:0]        state;
  logic [3:0]        cnt;
  opcode_t           op;
  logic [ADDR_W-1:0] a_addr, b_addr, c_addr;
  logic              a_ok, all_ok;
  logic [CW-1:0]     cx, cy, cz;
  logic [POS_W-1:0]  pa, pb, pc;
  logic signed [31:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [63:0] mul_p, prod_tmp;
  logic signed [63:0] vx, vy, vz;
  logic              neg_x, neg_y, neg_z;
  logic [MAG_W-1:0]  mgx, mgy, mgz, w;
  logic signed [6:0] sh;
  logic [FR_W-1:0]   fx, fy, fz;
  logic [LEN2_W-1:0] len2;
  logic [63:0]       sq_x, sq_r, sq_bit;
  logic [LEN_W-1:0]  len, rem;
  logic [DIV_BITS-1:0] low, quo;
  logic [1:0]        ci, corner;
  logic              phase;
  nrm_t              qx, qy, qz;
  logic              pres;
  logic              clr_reply;
  logic [ADDR_W-1:0] clr_cnt;

  // memories
  logic [POS_W-1:0]  pos_mem [VERTEX_COUNT];
  logic [POS_W-1:0]  pos_rdata;
  logic [ADDR_W-1:0] pos_raddr;
  logic              pos_we;
  logic [SMEM_W-1:0] sum_mem [VERTEX_COUNT];
  logic [SMEM_W-1:0] sum_rdata, sum_wdata;
  logic [ADDR_W-1:0] sum_raddr, sum_waddr;
  logic              sum_we;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[a_addr] <= {cx, cy, cz};
    end
    pos_rdata <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rdata <= sum_mem[sum_raddr];
  end

  function automatic logic signed [31:0] edge_diff(input logic [CW-1:0] p,
                                                   input logic [CW-1:0] q);
    logic signed [33:0] d;
    logic [33:0] m;
    logic [31:0] ms;
    d = $signed({{(34-CW){p[CW-1]}}, p}) - $signed({{(34-CW){q[CW-1]}}, q});
    m = d[33] ? 34'(-d) : 34'(d);
    m = m >> DIFF_SHR;
    ms = m[31:0];
    return d[33] ? $signed(32'(0) - ms) : $signed(ms);
  endfunction

  function automatic logic [MAG_W-1:0] abs64(input logic signed [63:0] v);
    logic [63:0] n;
    n = 64'(0) - 64'(v);
    return v[63] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  function automatic logic [FR_W-1:0] align(input logic [MAG_W-1:0] m,
                                            input logic signed [6:0] s);
    logic [MAG_W-1:0] r;
    logic [6:0] ns;
    ns = 7'(0) - 7'(s);
    if (!s[6]) begin
      r = m >> s[5:0];
    end else begin
      r = m << ns[5:0];
    end
    return r[FR_W-1:0];
  endfunction

  function automatic nrm_t sat_q(input logic [DIV_BITS-1:0] r, input logic neg);
    logic [DIV_BITS-1:0] n;
    n = 16'(0) - r;
    if (neg) begin
      return (r >= 16'd32768) ? NRM_MIN : $signed(n);
    end
    return (r >= 16'd32767) ? NRM_MAX : $signed(r);
  endfunction

  function automatic sum_t sat_add(input sum_t s, input nrm_t q);
    logic signed [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W-NRM_W+1){q[NRM_W-1]}}, q};
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return t[SUM_W-1:0];
  endfunction

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_c;
  assign mul_c = mul_a * mul_b;

  always_ff @(posedge clk) begin
    mul_p <= mul_c;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_FMUL) begin
      case (cnt)
        4'd0: begin mul_a = e2y; mul_b = e1z; end
        4'd1: begin mul_a = e2z; mul_b = e1y; end
        4'd2: begin mul_a = e2z; mul_b = e1x; end
        4'd3: begin mul_a = e2x; mul_b = e1z; end
        4'd4: begin mul_a = e2x; mul_b = e1y; end
        4'd5: begin mul_a = e2y; mul_b = e1x; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == S_NSQ) begin
      case (cnt)
        4'd0: begin mul_a = $signed({2'b00, fx}); mul_b = $signed({2'b00, fx}); end
        4'd1: begin mul_a = $signed({2'b00, fy}); mul_b = $signed({2'b00, fy}); end
        4'd2: begin mul_a = $signed({2'b00, fz}); mul_b = $signed({2'b00, fz}); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // memory address and write selection
  logic [ADDR_W-1:0] corner_addr;
  sum_t old_x, old_y, old_z, new_x, new_y, new_z;
  logic old_touched;

  always_comb begin
    case (corner)
      2'd0:    corner_addr = a_addr;
      2'd1:    corner_addr = b_addr;
      default: corner_addr = c_addr;
    endcase
    case (cnt)
      4'd0:    pos_raddr = a_addr;
      4'd1:    pos_raddr = b_addr;
      default: pos_raddr = c_addr;
    endcase
    pos_we      = (state == S_LOAD) && a_ok;
    sum_raddr   = (state == S_FACC) ? corner_addr : a_addr;
    old_touched = sum_rdata[SMEM_W-1];
    old_x = sum_rdata[3*SUM_W-1:2*SUM_W];
    old_y = sum_rdata[2*SUM_W-1:SUM_W];
    old_z = sum_rdata[SUM_W-1:0];
    new_x = old_touched ? sat_add(old_x, qx) : SUM_W'(qx);
    new_y = old_touched ? sat_add(old_y, qy) : SUM_W'(qy);
    new_z = old_touched ? sat_add(old_z, qz) : SUM_W'(qz);
    if (state == S_CLR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_cnt;
      sum_wdata = '0;
    end else begin
      sum_we    = (state == S_FACC) && phase;
      sum_waddr = corner_addr;
      sum_wdata = {1'b1, new_x, new_y, new_z};
    end
  end

  // square root and divider steps
  logic [63:0] sq_t, sq_r_next;
  logic        sq_ge;
  logic [FR_W-1:0] div_m;
  logic [45:0] div_num;
  logic [LEN_W:0] div_t;
  logic        div_ge;
  logic [DIV_BITS-1:0] quo_next;
  logic        div_neg;

  always_comb begin
    sq_t      = sq_r + sq_bit;
    sq_ge     = sq_x >= sq_t;
    sq_r_next = sq_ge ? ((sq_r >> 1) + sq_bit) : (sq_r >> 1);
    case (ci)
      2'd0:    begin div_m = fx; div_neg = neg_x; end
      2'd1:    begin div_m = fy; div_neg = neg_y; end
      default: begin div_m = fz; div_neg = neg_z; end
    endcase
    div_num  = {1'b0, div_m, 15'b0} + 46'(len >> 1);
    div_t    = {rem, low[DIV_BITS-1]};
    div_ge   = div_t >= {1'b0, len};
    quo_next = {quo[DIV_BITS-2:0], div_ge};
  end

  logic [31:0] cxz, cyz, czz;
  assign cxz = {{(32-PORT_CW){1'b0}}, coord_x};
  assign cyz = {{(32-PORT_CW){1'b0}}, coord_y};
  assign czz = {{(32-PORT_CW){1'b0}}, coord_z};

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
      done      <= 1'b0;
      present   <= 1'b0;
      normal_x  <= '0;
      normal_y  <= '0;
      normal_z  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op     <= opcode;
            a_addr <= ADDR_W'(index_a);
            b_addr <= ADDR_W'(index_b);
            c_addr <= ADDR_W'(index_c);
            a_ok   <= {22'b0, index_a} < VERTEX_COUNT;
            all_ok <= ({22'b0, index_a} < VERTEX_COUNT) &&
                      ({22'b0, index_b} < VERTEX_COUNT) &&
                      ({22'b0, index_c} < VERTEX_COUNT);
            cx     <= cxz[CW-1:0];
            cy     <= cyz[CW-1:0];
            cz     <= czz[CW-1:0];
            cnt    <= '0;
            pres   <= 1'b0;
            case (opcode)
              OP_LOAD: state <= S_LOAD;
              OP_FACE: state <= S_FRD;
              OP_READ: state <= S_RRD;
              OP_CLEAR: begin
                state     <= S_CLR;
                clr_cnt   <= '0;
                clr_reply <= 1'b1;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_ADDR) begin
            state <= S_IDLE;
            if (clr_reply) begin
              done     <= 1'b1;
              present  <= 1'b0;
              normal_x <= '0;
              normal_y <= '0;
              normal_z <= '0;
            end
          end
        end
        S_LOAD, S_DONE: begin
          state    <= S_IDLE;
          done     <= 1'b1;
          present  <= 1'b0;
          normal_x <= '0;
          normal_y <= '0;
          normal_z <= '0;
        end
        S_FRD: begin
          if (!all_ok) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
            case (cnt)
              4'd1:    pa <= pos_rdata;
              4'd2:    pb <= pos_rdata;
              4'd3:    pc <= pos_rdata;
              default: ;
            endcase
            if (cnt == 4'd3) begin
              state <= S_FDIFF;
            end
          end
        end
        S_FDIFF: begin
          e1x   <= edge_diff(pb[3*CW-1:2*CW], pa[3*CW-1:2*CW]);
          e1y   <= edge_diff(pb[2*CW-1:CW],   pa[2*CW-1:CW]);
          e1z   <= edge_diff(pb[CW-1:0],      pa[CW-1:0]);
          e2x   <= edge_diff(pc[3*CW-1:2*CW], pa[3*CW-1:2*CW]);
          e2y   <= edge_diff(pc[2*CW-1:CW],   pa[2*CW-1:CW]);
          e2z   <= edge_diff(pc[CW-1:0],      pa[CW-1:0]);
          cnt   <= '0;
          state <= S_FMUL;
        end
        S_FMUL: begin
          // products come back through the mul_p register; pairs form one component
          cnt <= cnt + 1'b1;
          case (cnt)
            4'd1, 4'd3, 4'd5: prod_tmp <= mul_p;
            4'd2:    vx <= prod_tmp - mul_p;
            4'd4:    vy <= prod_tmp - mul_p;
            4'd6:    vz <= prod_tmp - mul_p;
            default: ;
          endcase
          if (cnt == 4'd6) begin
            state <= S_NMAG;
          end
        end
        S_RRD: begin
          state <= S_RCHK;
        end
        S_RCHK: begin
          if (!a_ok || !old_touched) begin
            state <= S_DONE;
          end else begin
            vx    <= 64'(old_x);
            vy    <= 64'(old_y);
            vz    <= 64'(old_z);
            pres  <= 1'b1;
            state <= S_NMAG;
          end
        end
        S_NMAG: begin
          mgx   <= abs64(vx);
          mgy   <= abs64(vy);
          mgz   <= abs64(vz);
          neg_x <= vx[63];
          neg_y <= vy[63];
          neg_z <= vz[63];
          // top bit of the largest magnitude is the top bit of the or
          w     <= abs64(vx) | abs64(vy) | abs64(vz);
          sh    <= '0;
          if ((abs64(vx) | abs64(vy) | abs64(vz)) == '0) begin
            qx    <= '0;
            qy    <= '0;
            qz    <= '0;
            state <= S_NEND;
          end else begin
            state <= S_NSH;
          end
        end
        S_NSH: begin
          if (|w[MAG_W-1:34]) begin
            w  <= w >> 4;
            sh <= sh + 7'sd4;
          end else if (|w[MAG_W-1:30]) begin
            w  <= w >> 1;
            sh <= sh + 7'sd1;
          end else if (~|w[29:26]) begin
            w  <= w << 4;
            sh <= sh - 7'sd4;
          end else if (!w[29]) begin
            w  <= w << 1;
            sh <= sh - 7'sd1;
          end else begin
            state <= S_NAPP;
          end
        end
        S_NAPP: begin
          fx    <= align(mgx, sh);
          fy    <= align(mgy, sh);
          fz    <= align(mgz, sh);
          len2  <= '0;
          cnt   <= '0;
          state <= S_NSQ;
        end
        S_NSQ: begin
          cnt <= cnt + 1'b1;
          if (cnt != 4'd0) begin
            len2 <= len2 + mul_p[LEN2_W-1:0];
          end
          if (cnt == 4'd3) begin
            sq_x   <= 64'(len2 + mul_p[LEN2_W-1:0]);
            sq_r   <= '0;
            sq_bit <= 64'd1 << 62;
            state  <= S_NSQRT;
          end
        end
        S_NSQRT: begin
          if (sq_ge) begin
            sq_x <= sq_x - sq_t;
          end
          sq_r   <= sq_r_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            len   <= sq_r_next[LEN_W-1:0];
            ci    <= '0;
            state <= S_NDSET;
          end
        end
        S_NDSET: begin
          rem   <= LEN_W'(div_num[45:DIV_BITS]);
          low   <= div_num[DIV_BITS-1:0];
          quo   <= '0;
          cnt   <= '0;
          state <= S_NDIV;
        end
        S_NDIV: begin
          rem <= div_ge ? LEN_W'(div_t - {1'b0, len}) : div_t[LEN_W-1:0];
          low <= low << 1;
          quo <= quo_next;
          cnt <= cnt + 1'b1;
          if (cnt == 4'(DIV_BITS - 1)) begin
            case (ci)
              2'd0:    qx <= sat_q(quo_next, div_neg);
              2'd1:    qy <= sat_q(quo_next, div_neg);
              default: qz <= sat_q(quo_next, div_neg);
            endcase
            ci <= ci + 1'b1;
            state <= (ci == 2'd2) ? S_NEND : S_NDSET;
          end
        end
        S_NEND: begin
          if (op == OP_FACE) begin
            corner <= '0;
            phase  <= 1'b0;
            state  <= S_FACC;
          end else begin
            state    <= S_IDLE;
            done     <= 1'b1;
            present  <= pres;
            normal_x <= qx;
            normal_y <= qy;
            normal_z <= qz;
          end
        end
        S_FACC: begin
          // read a corner, then write it back before the next corner is read
          phase <= ~phase;
          if (phase) begin
            corner <= corner + 1'b1;
            if (corner == 2'd2) begin
              state <= S_DONE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/svna_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svna_checker
// Port-level checks of the command channel and of the result contents.
// ----------------------------------------------------------------------------
module svna_checker (
  input wire              clk,
  input wire              rst,
  input wire              start,
  input wire              busy,
  input wire [1:0]        opcode,
  input wire              done,
  input wire              present,
  input wire [15:0]       normal_x,
  input wire [15:0]       normal_y,
  input wire [15:0]       normal_z
);
  import svna_pkg::*;

  logic [1:0] last_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_op <= OP_LOAD;
    end else if (start && !busy) begin
      last_op <= opcode;
    end
  end

  // every transfer keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after a transfer");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result not at the end of a busy period");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    done && !present |-> normal_x == 16'd0 && normal_y == 16'd0 && normal_z == 16'd0)
    else $error("absent result carries a nonzero normal");

  a_present_only_read: assert property (@(posedge clk) disable iff (rst)
    done && last_op != OP_READ |-> !present)
    else $error("present set on a non-read result");

endmodule

bind smooth_vertex_normal_accumulator svna_checker u_svna_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .opcode   (opcode),
  .done     (done),
  .present  (present),
  .normal_x (normal_x),
  .normal_y (normal_y),
  .normal_z (normal_z)
);
`default_nettype wire
